FILE: hdl/trdm_pkg.sv
// ----------------------------------------------------------------------------
// trdm_pkg
// Shared types and constants of the triangle rasterizer with depth and MSAA.
// ----------------------------------------------------------------------------
package trdm_pkg;

    // fixed field widths
    localparam int CoordW = 13;
    localparam int ZW     = 16;
    localparam int ColW   = 24;
    localparam int WonW   = 15;
    localparam int AddrW  = 3;

    // edge coefficient width (vertex difference, sign folded in)
    localparam int CoefW  = 15;
    // signed area width
    localparam int AreaW  = 30;
    // magnitude of a covered barycentric weight, bounded by the area
    localparam int WW     = 30;

    // register byte address
    localparam logic [AddrW-1:0] REG_MSAA_ENABLE = 3'h0;

    typedef enum logic [1:0] {
        MODE_DRAW      = 2'd0,
        MODE_READ      = 2'd1,
        MODE_CLR_COLOR = 2'd2,
        MODE_CLR_DEPTH = 2'd3
    } t_mode;

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_CLEAR   = 15'h0002,
        S_RD_WAIT = 15'h0004,
        S_RD_CAP  = 15'h0008,
        S_AREA    = 15'h0010,
        S_BOX     = 15'h0020,
        S_PIX     = 15'h0040,
        S_LOAD    = 15'h0080,
        S_EDGE    = 15'h0100,
        S_MUL     = 15'h0200,
        S_SUM     = 15'h0400,
        S_DIV     = 15'h0800,
        S_TEST    = 15'h1000,
        S_WB      = 15'h2000,
        S_DONE    = 15'h4000
    } t_state;

endpackage

FILE: hdl/trdm_ram.sv
// ----------------------------------------------------------------------------
// trdm_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module trdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/triangle_raster_depth_msaa_top.sv
// ----------------------------------------------------------------------------
// triangle_raster_depth_msaa_top
// Edge-function triangle rasterizer with per-sample depth test, 4x MSAA
// additive color or single-sample overwrite, pixel read and store clears.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         i_valid / o_stall      i_mode, i_ax .. i_cz, i_color_rgb
//  output    out        o_valid / i_stall      o_pixel_color, o_samples_won
//  config    in         APB psel/penable       paddr, pwdata, prdata
//
//  Draw: setup in S_AREA and S_BOX, then per bounding-box pixel S_PIX and
//  S_LOAD, per sample S_EDGE and S_MUL, per covered sample S_SUM, the serial
//  divider for depth in S_DIV and S_TEST, then S_WB; S_DONE hands over
//  the result. Read: S_RD_WAIT, S_RD_CAP and S_DONE. Clear: one entry of
//  the depth or color memory each cycle, over all of its entries.
//  After reset a clearing pass over both memories runs with o_stall high.
//  o_stall is low only when idle; a pending result waits for i_stall to
//  drop while the next transfer may already be taken.
// ----------------------------------------------------------------------------
module triangle_raster_depth_msaa_top #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 64,
    parameter int SUBPIXEL_BITS = 4,
    parameter int DEPTH_BITS    = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_mode,
    input  logic [trdm_pkg::CoordW-1:0]        i_ax,
    input  logic [trdm_pkg::CoordW-1:0]        i_ay,
    input  logic [trdm_pkg::ZW-1:0]            i_az,
    input  logic [trdm_pkg::CoordW-1:0]        i_bx,
    input  logic [trdm_pkg::CoordW-1:0]        i_by,
    input  logic [trdm_pkg::ZW-1:0]            i_bz,
    input  logic [trdm_pkg::CoordW-1:0]        i_cx,
    input  logic [trdm_pkg::CoordW-1:0]        i_cy,
    input  logic [trdm_pkg::ZW-1:0]            i_cz,
    input  logic [trdm_pkg::ColW-1:0]          i_color_rgb,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [trdm_pkg::ColW-1:0]          o_pixel_color,
    output logic [trdm_pkg::WonW-1:0]          o_samples_won,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [trdm_pkg::AddrW-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    import trdm_pkg::*;

    localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW   = $clog2(NPIX);
    localparam int XW   = $clog2(SCREEN_WIDTH);
    localparam int YW   = $clog2(SCREEN_HEIGHT);
    localparam int DB   = DEPTH_BITS;
    localparam int RW   = 5 * DB;
    localparam int KW   = $clog2(DB);
    localparam int PRW  = WW + DB;
    localparam int NW   = WW + DB + 2;
    localparam int CW   = ((XW > YW) ? XW : YW) + SUBPIXEL_BITS + 2;
    localparam int PW   = ((CW > CoordW) ? CW : CoordW) + 1;
    localparam int EW   = CoefW + PW + 1;
    localparam int QOFF = 1 << (SUBPIXEL_BITS - 2);

    // state
    t_state                  r_state, n_state;
    logic                    r_msaa;
    logic                    r_ovalid, n_ovalid;
    logic [ColW-1:0]         r_out_col, n_out_col;
    logic [WonW-1:0]         r_out_won, n_out_won;
    logic [ColW-1:0]         r_res_col, n_res_col;
    logic [WonW-1:0]         r_won, n_won;
    logic                    r_clr_color, n_clr_color;
    logic                    r_clr_depth, n_clr_depth;
    logic                    r_clr_result, n_clr_result;
    logic [AW-1:0]           r_addr, n_addr;
    // triangle
    logic signed [CoordW-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [CoordW-1:0] n_ax, n_ay, n_bx, n_by, n_cx, n_cy;
    logic [DB-1:0]           r_az, r_bz, r_cz, n_az, n_bz, n_cz;
    logic [ColW-1:0]         r_col, n_col;
    logic signed [AreaW-1:0] r_area, n_area;
    logic [WW-1:0]           r_aa, n_aa;
    logic signed [CoefW-1:0] r_ex [3];
    logic signed [CoefW-1:0] r_ey [3];
    logic signed [CoefW-1:0] n_ex [3];
    logic signed [CoefW-1:0] n_ey [3];
    logic [XW-1:0]           r_x0, r_x1, r_i, n_x0, n_x1, n_i;
    logic [YW-1:0]           r_y0, r_y1, r_j, n_y0, n_y1, n_j;
    // per pixel and per sample
    logic [1:0]              r_s, n_s;
    logic [2:0]              r_n, n_n;
    logic [RW-1:0]           r_row, n_row;
    logic [ColW-1:0]         r_pcol, n_pcol;
    logic signed [EW-1:0]    r_w [3];
    logic signed [EW-1:0]    n_w [3];
    logic [PRW-1:0]          r_p [3];
    logic [PRW-1:0]          n_p [3];
    logic [NW-1:0]           r_rem, n_rem, r_dvs, n_dvs;
    logic [DB-1:0]           r_q, n_q;
    logic [KW-1:0]           r_k, n_k;

    // memories
    logic [RW-1:0]           depth_rdata, depth_wdata;
    logic [ColW-1:0]         color_rdata, color_wdata;
    logic                    depth_we, color_we;

    // edge origins: edge 0 from b, edge 1 from c, edge 2 from a
    logic signed [CoordW-1:0] ox [3];
    logic signed [CoordW-1:0] oy [3];

    assign ox[0] = r_bx;
    assign oy[0] = r_by;
    assign ox[1] = r_cx;
    assign oy[1] = r_cy;
    assign ox[2] = r_ax;
    assign oy[2] = r_ay;

    function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] j,
                                               input logic [XW-1:0] i);
        pix_addr = AW'(AW'(j) * AW'(SCREEN_WIDTH)) + AW'(i);
    endfunction

    // color gains channel * n / 4 per channel, saturating
    function automatic logic [ColW-1:0] add_scaled(input logic [ColW-1:0] pix,
                                                   input logic [ColW-1:0] col,
                                                   input logic [2:0] n);
        logic [ColW-1:0] res;
        logic [10:0]     prod;
        logic [9:0]      sum;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            prod = 11'(col[8*ch +: 8]) * 11'(n);
            sum  = 10'(pix[8*ch +: 8]) + 10'(prod >> 2);
            res[8*ch +: 8] = (sum > 10'd255) ? 8'd255 : sum[7:0];
        end
        return res;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MSAA_ENABLE) ? {31'd0, r_msaa} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msaa <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr == REG_MSAA_ENABLE) begin
            r_msaa <= pwdata[0];
        end
    end

    // handshake outputs
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_pixel_color = r_out_col;
    assign o_samples_won = r_out_won;

    // memory instances
    trdm_ram #(.WIDTH(RW), .DEPTH(NPIX)) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (depth_we),
        .i_waddr (r_addr),
        .i_wdata (depth_wdata),
        .i_raddr (r_addr),
        .o_rdata (depth_rdata)
    );

    trdm_ram #(.WIDTH(ColW), .DEPTH(NPIX)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (color_we),
        .i_waddr (r_addr),
        .i_wdata (color_wdata),
        .i_raddr (r_addr),
        .o_rdata (color_rdata)
    );

    // sequencer
    always_comb begin
        logic signed [CoordW-1:0] minx, maxx, miny, maxy;
        logic signed [CoordW-1:0] lox, hix, loy, hiy;
        logic signed [CW-1:0]     px, py;
        logic signed [PW-1:0]     dx, dy;
        logic                     neg, cov, last, won_pix;
        logic [2:0]               slot;
        logic [DB-1:0]            old_z;
        logic [2:0]               n_inc;

        n_state      = r_state;
        n_ovalid     = r_ovalid;
        n_out_col    = r_out_col;
        n_out_won    = r_out_won;
        n_res_col    = r_res_col;
        n_won        = r_won;
        n_clr_color  = r_clr_color;
        n_clr_depth  = r_clr_depth;
        n_clr_result = r_clr_result;
        n_addr       = r_addr;
        n_ax = r_ax; n_ay = r_ay; n_bx = r_bx; n_by = r_by; n_cx = r_cx; n_cy = r_cy;
        n_az = r_az; n_bz = r_bz; n_cz = r_cz;
        n_col  = r_col;
        n_area = r_area;
        n_aa   = r_aa;
        n_ex   = r_ex;
        n_ey   = r_ey;
        n_x0 = r_x0; n_x1 = r_x1; n_i = r_i;
        n_y0 = r_y0; n_y1 = r_y1; n_j = r_j;
        n_s    = r_s;
        n_n    = r_n;
        n_row  = r_row;
        n_pcol = r_pcol;
        n_w    = r_w;
        n_p    = r_p;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_q    = r_q;
        n_k    = r_k;

        depth_we    = 1'b0;
        color_we    = 1'b0;
        depth_wdata = r_row;
        color_wdata = r_pcol;

        minx = '0; maxx = '0; miny = '0; maxy = '0;
        lox = '0; hix = '0; loy = '0; hiy = '0;
        px = '0; py = '0; dx = '0; dy = '0;
        neg = 1'b0; cov = 1'b0; won_pix = 1'b0;
        last  = r_msaa ? (r_s == 2'd3) : 1'b1;
        slot  = r_msaa ? {1'b0, r_s} : 3'd4;
        old_z = r_row[32'(slot) * DB +: DB];
        n_inc = 3'd0;

        // result register drains independently
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ax = $signed(i_ax); n_ay = $signed(i_ay);
                    n_bx = $signed(i_bx); n_by = $signed(i_by);
                    n_cx = $signed(i_cx); n_cy = $signed(i_cy);
                    n_az = DB'({8'd0, i_az});
                    n_bz = DB'({8'd0, i_bz});
                    n_cz = DB'({8'd0, i_cz});
                    n_col     = i_color_rgb;
                    n_res_col = '0;
                    n_won     = '0;
                    unique case (t_mode'(i_mode))
                        MODE_DRAW: begin
                            n_state = S_AREA;
                        end
                        MODE_READ: begin
                            if (!i_ax[CoordW-1] && !i_ay[CoordW-1]
                                && i_ax < CoordW'(SCREEN_WIDTH)
                                && i_ay < CoordW'(SCREEN_HEIGHT)) begin
                                n_addr  = pix_addr(i_ay[YW-1:0], i_ax[XW-1:0]);
                                n_state = S_RD_WAIT;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        MODE_CLR_COLOR: begin
                            n_clr_color  = 1'b1;
                            n_clr_depth  = 1'b0;
                            n_clr_result = 1'b1;
                            n_addr       = '0;
                            n_state      = S_CLEAR;
                        end
                        MODE_CLR_DEPTH: begin
                            n_clr_color  = 1'b0;
                            n_clr_depth  = 1'b1;
                            n_clr_result = 1'b1;
                            n_addr       = '0;
                            n_state      = S_CLEAR;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            // sweep of one memory row per cycle
            S_CLEAR: begin
                depth_we    = r_clr_depth;
                color_we    = r_clr_color;
                depth_wdata = '1;
                color_wdata = '0;
                if (r_addr == AW'(NPIX - 1)) begin
                    n_state = r_clr_result ? S_DONE : S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            S_RD_WAIT: begin
                n_state = S_RD_CAP;
            end

            S_RD_CAP: begin
                n_res_col = color_rdata;
                n_state   = S_DONE;
            end

            // signed doubled area
            S_AREA: begin
                n_area = AreaW'(AreaW'(r_bx - r_ax) * AreaW'(r_cy - r_ay))
                       - AreaW'(AreaW'(r_by - r_ay) * AreaW'(r_cx - r_ax));
                n_state = S_BOX;
            end

            // winding, edge coefficients and clipped bounding box
            S_BOX: begin
                neg  = r_area[AreaW-1];
                n_aa = neg ? WW'(-r_area) : WW'(r_area);
                n_ex[0] = CoefW'(r_cx) - CoefW'(r_bx);
                n_ey[0] = CoefW'(r_cy) - CoefW'(r_by);
                n_ex[1] = CoefW'(r_ax) - CoefW'(r_cx);
                n_ey[1] = CoefW'(r_ay) - CoefW'(r_cy);
                n_ex[2] = CoefW'(r_bx) - CoefW'(r_ax);
                n_ey[2] = CoefW'(r_by) - CoefW'(r_ay);
                if (neg) begin
                    for (int k = 0; k < 3; k++) begin
                        n_ex[k] = -n_ex[k];
                        n_ey[k] = -n_ey[k];
                    end
                end
                minx = (r_ax < r_bx) ? r_ax : r_bx;
                minx = (r_cx < minx) ? r_cx : minx;
                maxx = (r_ax > r_bx) ? r_ax : r_bx;
                maxx = (r_cx > maxx) ? r_cx : maxx;
                miny = (r_ay < r_by) ? r_ay : r_by;
                miny = (r_cy < miny) ? r_cy : miny;
                maxy = (r_ay > r_by) ? r_ay : r_by;
                maxy = (r_cy > maxy) ? r_cy : maxy;
                lox = minx >>> SUBPIXEL_BITS;
                hix = maxx >>> SUBPIXEL_BITS;
                loy = miny >>> SUBPIXEL_BITS;
                hiy = maxy >>> SUBPIXEL_BITS;
                n_x0 = lox[CoordW-1] ? '0 : lox[XW-1:0];
                n_y0 = loy[CoordW-1] ? '0 : loy[YW-1:0];
                n_x1 = (hix > $signed(CoordW'(SCREEN_WIDTH - 1)))
                     ? XW'(SCREEN_WIDTH - 1) : hix[XW-1:0];
                n_y1 = (hiy > $signed(CoordW'(SCREEN_HEIGHT - 1)))
                     ? YW'(SCREEN_HEIGHT - 1) : hiy[YW-1:0];
                if (r_area == '0 || hix[CoordW-1] || hiy[CoordW-1]
                    || lox > $signed(CoordW'(SCREEN_WIDTH - 1))
                    || loy > $signed(CoordW'(SCREEN_HEIGHT - 1))) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = n_x0;
                    n_j     = n_y0;
                    n_addr  = pix_addr(n_y0, n_x0);
                    n_state = S_PIX;
                end
            end

            S_PIX: begin
                n_state = S_LOAD;
            end

            // read data of this pixel is valid now
            S_LOAD: begin
                n_row   = depth_rdata;
                n_pcol  = color_rdata;
                n_s     = 2'd0;
                n_n     = 3'd0;
                n_state = S_EDGE;
            end

            // edge functions at the sample point
            S_EDGE: begin
                if (r_msaa) begin
                    px = $signed((CW'(r_i) << SUBPIXEL_BITS)
                                 + CW'(r_s[1] ? 3 * QOFF : QOFF));
                    py = $signed((CW'(r_j) << SUBPIXEL_BITS)
                                 + CW'(r_s[0] ? 3 * QOFF : QOFF));
                end else begin
                    px = $signed((CW'(r_i) << SUBPIXEL_BITS) + CW'(2 * QOFF));
                    py = $signed((CW'(r_j) << SUBPIXEL_BITS) + CW'(2 * QOFF));
                end
                for (int k = 0; k < 3; k++) begin
                    dx = PW'(px) - PW'(ox[k]);
                    dy = PW'(py) - PW'(oy[k]);
                    n_w[k] = EW'(EW'(r_ex[k]) * EW'(dy)) - EW'(EW'(r_ey[k]) * EW'(dx));
                end
                n_state = S_MUL;
            end

            // coverage and weighted depths
            S_MUL: begin
                cov = !r_w[0][EW-1] && !r_w[1][EW-1] && !r_w[2][EW-1];
                n_p[0] = PRW'(r_w[0][WW-1:0]) * PRW'(r_az);
                n_p[1] = PRW'(r_w[1][WW-1:0]) * PRW'(r_bz);
                n_p[2] = PRW'(r_w[2][WW-1:0]) * PRW'(r_cz);
                if (cov) begin
                    n_state = S_SUM;
                end else if (last) begin
                    n_state = S_WB;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = S_EDGE;
                end
            end

            // numerator with rounding half up
            S_SUM: begin
                n_rem   = NW'(r_p[0]) + NW'(r_p[1]) + NW'(r_p[2]) + NW'(r_aa >> 1);
                n_dvs   = NW'(r_aa) << (DB - 1);
                n_q     = '0;
                n_k     = KW'(DB - 1);
                n_state = S_DIV;
            end

            // restoring divide, one quotient bit a cycle
            S_DIV: begin
                if (r_rem >= r_dvs) begin
                    n_rem = r_rem - r_dvs;
                    n_q   = {r_q[DB-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[DB-2:0], 1'b0};
                end
                n_dvs = r_dvs >> 1;
                if (r_k == '0) begin
                    n_state = S_TEST;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end

            // strictly-less depth test
            S_TEST: begin
                if (r_q < old_z) begin
                    n_row[32'(slot) * DB +: DB] = r_q;
                    n_n = r_n + 1'b1;
                end
                if (last) begin
                    n_state = S_WB;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = S_EDGE;
                end
            end

            // write back the pixel and step through the box
            S_WB: begin
                won_pix  = (r_n != 3'd0);
                depth_we = 1'b1;
                color_we = 1'b1;
                if (won_pix) begin
                    color_wdata = r_msaa ? add_scaled(r_pcol, r_col, r_n) : r_col;
                end
                n_inc = r_n;
                n_won = r_won + WonW'(n_inc);
                if (r_i == r_x1) begin
                    n_i = r_x0;
                    if (r_j == r_y1) begin
                        n_state = S_DONE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_PIX;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_PIX;
                end
                n_addr = pix_addr(n_j, n_i);
            end

            // hand the result to the output register
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_out_col = r_res_col;
                    n_out_won = r_won;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_ovalid     <= 1'b0;
            r_clr_color  <= 1'b1;
            r_clr_depth  <= 1'b1;
            r_clr_result <= 1'b0;
            r_addr       <= '0;
        end else begin
            r_state      <= n_state;
            r_ovalid     <= n_ovalid;
            r_clr_color  <= n_clr_color;
            r_clr_depth  <= n_clr_depth;
            r_clr_result <= n_clr_result;
            r_addr       <= n_addr;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_out_col <= n_out_col;
        r_out_won <= n_out_won;
        r_res_col <= n_res_col;
        r_won     <= n_won;
        r_ax <= n_ax; r_ay <= n_ay; r_bx <= n_bx; r_by <= n_by;
        r_cx <= n_cx; r_cy <= n_cy;
        r_az <= n_az; r_bz <= n_bz; r_cz <= n_cz;
        r_col  <= n_col;
        r_area <= n_area;
        r_aa   <= n_aa;
        r_ex   <= n_ex;
        r_ey   <= n_ey;
        r_x0 <= n_x0; r_x1 <= n_x1; r_i <= n_i;
        r_y0 <= n_y0; r_y1 <= n_y1; r_j <= n_j;
        r_s    <= n_s;
        r_n    <= n_n;
        r_row  <= n_row;
        r_pcol <= n_pcol;
        r_w    <= n_w;
        r_p    <= n_p;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_q    <= n_q;
        r_k    <= n_k;
    end

endmodule

FILE: test/triangle_raster_depth_msaa_top_test.sv
// ----------------------------------------------------------------------------
// triangle_raster_depth_msaa_top_test
// Drives draw, read and clear requests into the rasterizer under random
// idling on both channels, keeps its own model of the depth and color stores
// and checks every result against it in order.
// ----------------------------------------------------------------------------
module triangle_raster_depth_msaa_top_test;
    import trdm_pkg::*;

    localparam int SW = 64;
    localparam int SH = 64;
    localparam int NPIX = SW * SH;
    localparam int WATCH_LIMIT = 2000000;

    typedef struct packed {
        t_mode             mode;
        logic [CoordW-1:0] ax, ay;
        logic [ZW-1:0]     az;
        logic [CoordW-1:0] bx, by;
        logic [ZW-1:0]     bz;
        logic [CoordW-1:0] cx, cy;
        logic [ZW-1:0]     cz;
        logic [ColW-1:0]   rgb;
    } t_req;

    typedef struct packed {
        logic [ColW-1:0] color;
        logic [WonW-1:0] won;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic o_stall_q = 1'b1;
    t_req cur = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [ColW-1:0] o_pixel_color;
    logic [WonW-1:0] o_samples_won;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // model state
    logic [ZW-1:0]   mdl_sdepth [NPIX*4];
    logic [ZW-1:0]   mdl_pdepth [NPIX];
    logic [ColW-1:0] mdl_color [NPIX];
    logic            mdl_msaa;

    t_req pending_reqs[$];
    t_res expected_res[$];
    int   errors = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_cycles = 0;
    int   quiet_cycles = 0;

    triangle_raster_depth_msaa_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(cur.mode), .i_ax(cur.ax), .i_ay(cur.ay), .i_az(cur.az),
        .i_bx(cur.bx), .i_by(cur.by), .i_bz(cur.bz),
        .i_cx(cur.cx), .i_cy(cur.cy), .i_cz(cur.cz), .i_color_rgb(cur.rgb),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pixel_color(o_pixel_color), .o_samples_won(o_samples_won),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint edge_fn(longint x0, longint y0, longint x1, longint y1,
                                       longint px, longint py);
        return (x1 - x0) * (py - y0) - (y1 - y0) * (px - x0);
    endfunction

    function automatic logic [ColW-1:0] blend_add(logic [ColW-1:0] pix, logic [ColW-1:0] c,
                                                   int n);
        logic [ColW-1:0] r;
        int s;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            s = pix[k*8 +: 8] + ((c[k*8 +: 8] * n) >> 2);
            if (s > 255) s = 255;
            r[k*8 +: 8] = s[7:0];
        end
        return r;
    endfunction

    // rasterize one request into the model stores
    function automatic t_res rasterize(t_req q);
        t_res r;
        longint ax, ay, bx, by, cx, cy, area, sgn, aa, px, py, w0, w1, w2, z;
        int ns, n, pix, won, slot;
        logic [ZW-1:0] cur_z;
        r = '0;
        won = 0;
        ax = $signed(q.ax); ay = $signed(q.ay);
        bx = $signed(q.bx); by = $signed(q.by);
        cx = $signed(q.cx); cy = $signed(q.cy);
        case (q.mode)
            MODE_READ: begin
                if (ax >= 0 && ax < SW && ay >= 0 && ay < SH)
                    r.color = mdl_color[ay * SW + ax];
            end
            MODE_CLR_COLOR: for (int k = 0; k < NPIX; k++) mdl_color[k] = '0;
            MODE_CLR_DEPTH: begin
                for (int k = 0; k < NPIX*4; k++) mdl_sdepth[k] = '1;
                for (int k = 0; k < NPIX; k++) mdl_pdepth[k] = '1;
            end
            default: begin
                area = edge_fn(ax, ay, bx, by, cx, cy);
                sgn = area < 0 ? -1 : 1;
                aa = area * sgn;
                ns = mdl_msaa ? 4 : 1;
                if (area != 0) begin
                    for (int j = 0; j < SH; j++) begin
                        for (int i = 0; i < SW; i++) begin
                            n = 0;
                            pix = j * SW + i;
                            for (int s = 0; s < ns; s++) begin
                                if (ns == 4) begin
                                    px = i * 16 + (s[1] ? 12 : 4);
                                    py = j * 16 + (s[0] ? 12 : 4);
                                    slot = pix * 4 + s;
                                    cur_z = mdl_sdepth[slot];
                                end else begin
                                    px = i * 16 + 8;
                                    py = j * 16 + 8;
                                    slot = pix;
                                    cur_z = mdl_pdepth[slot];
                                end
                                w0 = edge_fn(bx, by, cx, cy, px, py) * sgn;
                                w1 = edge_fn(cx, cy, ax, ay, px, py) * sgn;
                                w2 = edge_fn(ax, ay, bx, by, px, py) * sgn;
                                if (w0 >= 0 && w1 >= 0 && w2 >= 0) begin
                                    z = (w0 * q.az + w1 * q.bz + w2 * q.cz + aa / 2) / aa;
                                    if (z[ZW-1:0] < cur_z) begin
                                        if (ns == 4) mdl_sdepth[slot] = z[ZW-1:0];
                                        else mdl_pdepth[slot] = z[ZW-1:0];
                                        n++;
                                    end
                                end
                            end
                            if (n > 0) begin
                                mdl_color[pix] = (ns == 4) ?
                                    blend_add(mdl_color[pix], q.rgb, n) : q.rgb;
                                won += n;
                            end
                        end
                    end
                end
                r.won = won[WonW-1:0];
            end
        endcase
        return r;
    endfunction

    // driver: one transfer per accepted request
    always @(negedge i_clk) begin
        if (i_valid && !o_stall_q) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                cur <= pending_reqs.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid && i_rst_n && pending_reqs.size() > 0 &&
                     $urandom_range(99) >= idle_pct) begin
            cur <= pending_reqs.pop_front();
            i_valid <= 1'b1;
        end
    end

    // accept flag from the last rising edge
    always @(posedge i_clk) begin
        o_stall_q <= o_stall;
        if (i_rst_n && i_valid && !o_stall) expected_res.push_back(rasterize(cur));
    end

    // receiver stall, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_res.size() == 0) begin
                $display("%0t: unexpected result color=%h won=%0d", $time,
                         o_pixel_color, o_samples_won);
                errors++;
            end else begin
                t_res e;
                e = expected_res.pop_front();
                if (e.color !== o_pixel_color) begin
                    $display("%0t: pixel_color expected %h actual %h", $time,
                             e.color, o_pixel_color);
                    errors++;
                end
                if (e.won !== o_samples_won) begin
                    $display("%0t: samples_won expected %0d actual %0d", $time,
                             e.won, o_samples_won);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCH_LIMIT) begin
            $display("triangle_raster_depth_msaa_top_test NOT OK");
            $finish;
        end
    end

    task automatic write_msaa(bit en);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_MSAA_ENABLE; pwdata <= {31'b0, en};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mdl_msaa = en;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_req make_req(t_mode m);
        t_req q;
        q = '0;
        q.mode = m;
        q.az = ZW'($urandom); q.bz = ZW'($urandom); q.cz = ZW'($urandom);
        q.rgb = ColW'($urandom);
        return q;
    endfunction

    function automatic logic [CoordW-1:0] coord_near();
        int v;
        v = $urandom_range(99) < 85 ? $urandom_range(1100) - 40 : $urandom_range(8191);
        return v[CoordW-1:0];
    endfunction

    // random request; mostly small draws over the screen, some reads and clears
    function automatic t_req rand_req();
        t_req q;
        int pick, x0, y0;
        pick = $urandom_range(99);
        if (pick < 70) begin
            q = make_req(MODE_DRAW);
            if ($urandom_range(9) < 8) begin
                x0 = $urandom_range(1100) - 40;
                y0 = $urandom_range(1100) - 40;
                q.ax = x0[CoordW-1:0];
                q.ay = y0[CoordW-1:0];
                q.bx = CoordW'(x0 + $urandom_range(200) - 100);
                q.by = CoordW'(y0 + $urandom_range(200) - 100);
                q.cx = CoordW'(x0 + $urandom_range(200) - 100);
                q.cy = CoordW'(y0 + $urandom_range(200) - 100);
            end else begin
                q.ax = coord_near(); q.ay = coord_near();
                q.bx = coord_near(); q.by = coord_near();
                q.cx = coord_near(); q.cy = coord_near();
            end
            if ($urandom_range(3) == 0) begin
                q.az = ZW'(16'hffff - $urandom_range(2));
                q.bz = ZW'($urandom_range(1));
            end
        end else if (pick < 92) begin
            q = make_req(MODE_READ);
            q.ax = CoordW'($urandom_range(99) < 90 ? $urandom_range(SW-1) : $urandom);
            q.ay = CoordW'($urandom_range(99) < 90 ? $urandom_range(SH-1) : $urandom);
            q.bx = CoordW'($urandom); q.by = CoordW'($urandom);
            q.cx = CoordW'($urandom); q.cy = CoordW'($urandom);
        end else begin
            q = make_req($urandom_range(1) ? MODE_CLR_COLOR : MODE_CLR_DEPTH);
            q.ax = CoordW'($urandom); q.ay = CoordW'($urandom); q.bx = CoordW'($urandom);
        end
        return q;
    endfunction

    function automatic t_req tri_req(int x0, int y0, int x1, int y1, int x2, int y2,
                                     int z0, int z1, int z2, int c);
        t_req q;
        q = make_req(MODE_DRAW);
        q.ax = CoordW'(x0); q.ay = CoordW'(y0);
        q.bx = CoordW'(x1); q.by = CoordW'(y1);
        q.cx = CoordW'(x2); q.cy = CoordW'(y2);
        q.az = ZW'(z0); q.bz = ZW'(z1); q.cz = ZW'(z2); q.rgb = ColW'(c);
        return q;
    endfunction

    function automatic t_req read_req(int x, int y);
        t_req q;
        q = make_req(MODE_READ);
        q.ax = CoordW'(x); q.ay = CoordW'(y);
        return q;
    endfunction

    initial begin
        mdl_msaa = 1'b1;
        for (int k = 0; k < NPIX*4; k++) mdl_sdepth[k] = '1;
        for (int k = 0; k < NPIX; k++) begin
            mdl_pdepth[k] = '1;
            mdl_color[k] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: windings, extremes, overlap, degenerate, clipping, reads
        write_msaa(1'b1);
        pending_reqs.push_back(tri_req(16, 16, 200, 30, 40, 180, 100, 200, 300, 24'hffffff));
        pending_reqs.push_back(tri_req(16, 16, 40, 180, 200, 30, 100, 200, 300, 24'h804020));
        pending_reqs.push_back(tri_req(16, 16, 40, 180, 200, 30, 0, 0, 0, 24'h0000ff));
        pending_reqs.push_back(tri_req(0, 0, 16, 16, 32, 32, 0, 0, 0, 24'hffffff));
        pending_reqs.push_back(tri_req(-4096, -4096, 4095, -4096, -4096, 4095,
                                       65535, 65535, 65535, 24'h123456));
        pending_reqs.push_back(tri_req(-4096, -4096, 4095, -4096, -4096, 4095,
                                       65534, 65535, 0, 24'hff00ff));
        pending_reqs.push_back(tri_req(1000, 1000, 4095, 1000, 1000, 4095, 5, 5, 5, 24'h00ff00));
        pending_reqs.push_back(tri_req(4, 4, 12, 4, 4, 12, 10, 10, 10, 24'hf0f0f0));
        pending_reqs.push_back(read_req(0, 0));
        pending_reqs.push_back(read_req(1, 1));
        pending_reqs.push_back(read_req(63, 63));
        pending_reqs.push_back(read_req(64, 0));
        pending_reqs.push_back(read_req(-1, 5));
        pending_reqs.push_back(read_req(4095, -4096));
        pending_reqs.push_back(make_req(MODE_CLR_COLOR));
        pending_reqs.push_back(read_req(1, 1));
        pending_reqs.push_back(make_req(MODE_CLR_DEPTH));
        pending_reqs.push_back(tri_req(0, 0, 1023, 0, 0, 1023, 65535, 0, 65535, 24'h7f7f7f));
        pending_reqs.push_back(read_req(2, 2));
        wait_drained();

        write_msaa(1'b0);
        pending_reqs.push_back(tri_req(0, 0, 1023, 0, 0, 1023, 100, 100, 100, 24'habcdef));
        pending_reqs.push_back(tri_req(0, 0, 0, 1023, 1023, 0, 100, 100, 100, 24'h111111));
        pending_reqs.push_back(tri_req(0, 0, 1023, 0, 0, 1023, 99, 99, 99, 24'h222222));
        pending_reqs.push_back(read_req(3, 3));
        wait_drained();

        // random phases across idling patterns and both settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                3: begin idle_pct = 10; stall_pct = 10; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            write_msaa(ph % 2 == 0);
            if (ph == 4) hold_cycles = 3000;
            for (int k = 0; k < 24; k++) pending_reqs.push_back(rand_req());
            wait_drained();
        end
        stall_pct = 0;
        idle_pct = 0;
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_res.size() == 0)
            $display("triangle_raster_depth_msaa_top_test OK");
        else
            $display("triangle_raster_depth_msaa_top_test NOT OK");
        $finish;
    end
endmodule

FILE: files.f
hdl/trdm_pkg.sv
hdl/trdm_ram.sv
hdl/triangle_raster_depth_msaa_top.sv
test/triangle_raster_depth_msaa_top_test.sv
